### src/dftc_pkg.sv
package dftc_pkg;

    // character codes
    localparam logic [7:0] CHAR_NUL     = 8'd0;
    localparam logic [7:0] CHAR_NEWLINE = 8'd10;
    localparam logic [7:0] CHAR_DASH    = 8'd45;
    localparam logic [7:0] CHAR_ZERO    = 8'd48;
    localparam logic [7:0] CHAR_NINE    = 8'd57;

    // field widths
    localparam int CHAR_W = 8;
    localparam int LEN_W  = 7;
    localparam int CNT_W  = 3;

    // default sizing
    localparam int DEF_MAX_LENGTH = 100;
    localparam int DEF_NUM_FIELDS = 4;

    // triple search order 012, 013, 023, 123 over at most four slots
    localparam int FIELD_SLOTS = 4;
    localparam int NUM_TRIPLES = 4;

    typedef logic [1:0]       t_slot;
    typedef logic [LEN_W-1:0] t_len;

    localparam t_slot TRI_I [NUM_TRIPLES] = '{2'd0, 2'd0, 2'd0, 2'd1};
    localparam t_slot TRI_J [NUM_TRIPLES] = '{2'd1, 2'd1, 2'd2, 2'd2};
    localparam t_slot TRI_K [NUM_TRIPLES] = '{2'd2, 2'd3, 2'd3, 2'd3};

endpackage

### src/dash_field_triangle_checker_unit.sv
// Dash-separated stick-length line checker.
// Input channel: one character byte per request on i_char_code, accepted
// when i_in_valid and o_in_ready are both high. Digits build a field, a
// dash closes it, a NUL or newline ends the line.
// Output channel: one request per line end, held on o_out_valid until
// i_out_ready. It carries o_line_valid (NUM_FIELDS in-range fields, no bad
// characters), o_triangle_found and the first triple (order 012, 013,
// 023, 123) that meets the strict triangle inequality, zero when none.
// The result is registered as the terminator is accepted and shows in the
// cycle after. Throughput: one character per cycle while o_in_ready is high;
// each accepted character updates the line registers directly and the triple
// search sits between the stored lengths and the result register.
// Stall: o_in_ready falls only while a result waits and i_out_ready is
// low; the result register then holds until taken.
// Reset: clears the digit accumulator, field count, error flag and the
// output request; the length store is left as it is.
module dash_field_triangle_checker_unit #(
    parameter int MAX_LENGTH = dftc_pkg::DEF_MAX_LENGTH,
    parameter int NUM_FIELDS = dftc_pkg::DEF_NUM_FIELDS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [dftc_pkg::CHAR_W-1:0] i_char_code,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_line_valid,
    output logic                        o_triangle_found,
    output logic [dftc_pkg::LEN_W-1:0]  o_side_a,
    output logic [dftc_pkg::LEN_W-1:0]  o_side_b,
    output logic [dftc_pkg::LEN_W-1:0]  o_side_c
);
    import dftc_pkg::*;

    localparam int IDX_W = $clog2(NUM_FIELDS);
    localparam int MUL_W = LEN_W + 4;

    localparam t_len       LEN_MAX = LEN_W'(MAX_LENGTH);
    localparam t_len       LEN_SAT = LEN_W'(MAX_LENGTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(NUM_FIELDS);
    localparam logic [CNT_W-1:0] CNT_SAT  = CNT_W'(NUM_FIELDS + 1);

    // line state
    t_len             r_acc,   n_acc;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_err,   n_err;
    t_len             r_stick [NUM_FIELDS];

    // result register
    logic r_out_valid;
    logic r_line_valid, r_found;
    t_len r_side_a, r_side_b, r_side_c;

    logic             in_accept;
    logic             is_digit, is_dash, is_end;
    logic [3:0]       digit;
    logic [MUL_W-1:0] acc_mul;
    logic             close_ok;
    logic             store_en;
    logic [CNT_W-1:0] count_close;
    logic             line_ok;
    t_len             lens [FIELD_SLOTS];
    logic             found;
    t_len             sa, sb, sc;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_accept  = i_in_valid && o_in_ready;

    // character decode
    assign is_digit = (i_char_code >= CHAR_ZERO) && (i_char_code <= CHAR_NINE);
    assign is_dash  = (i_char_code == CHAR_DASH);
    assign is_end   = (i_char_code == CHAR_NUL) || (i_char_code == CHAR_NEWLINE);
    assign digit    = 4'(i_char_code - CHAR_ZERO);

    // decimal accumulate with saturation
    assign acc_mul = MUL_W'(r_acc) * MUL_W'(10) + MUL_W'(digit);

    // field close: in range, counted and stored while there is room
    assign close_ok    = (r_acc != '0) && (r_acc <= LEN_MAX);
    assign store_en    = close_ok && (r_count < CNT_FULL);
    assign count_close = (close_ok && (r_count < CNT_SAT)) ? r_count + 1'b1 : r_count;

    // next line state
    always_comb begin
        n_acc   = r_acc;
        n_count = r_count;
        n_err   = r_err;
        if (is_digit) begin
            n_acc = (acc_mul > MUL_W'(LEN_SAT)) ? LEN_SAT : acc_mul[LEN_W-1:0];
        end else if (is_dash) begin
            n_acc   = '0;
            n_count = count_close;
            n_err   = r_err || !close_ok;
        end else if (is_end) begin
            n_acc   = '0;
            n_count = '0;
            n_err   = 1'b0;
        end else begin
            n_err = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc   <= '0;
            r_count <= '0;
            r_err   <= 1'b0;
        end else if (in_accept) begin
            r_acc   <= n_acc;
            r_count <= n_count;
            r_err   <= n_err;
        end
    end

    // length store, written on every in-range close while there is room
    always_ff @(posedge i_clk) begin
        if (in_accept && (is_dash || is_end) && store_en) begin
            r_stick[r_count[IDX_W-1:0]] <= r_acc;
        end
    end

    // lengths as seen at line end, trailing field forwarded
    always_comb begin
        for (int n = 0; n < FIELD_SLOTS; n++) begin
            lens[n] = '0;
        end
        for (int n = 0; n < NUM_FIELDS; n++) begin
            lens[n] = (store_en && (r_count == CNT_W'(n))) ? r_acc : r_stick[n];
        end
    end

    assign line_ok = !r_err && (count_close == CNT_FULL);

    // first triple meeting the strict triangle inequality
    always_comb begin
        t_len ta, tb, tc;
        found = 1'b0;
        sa    = '0;
        sb    = '0;
        sc    = '0;
        for (int t = 0; t < NUM_TRIPLES; t++) begin
            ta = lens[TRI_I[t]];
            tb = lens[TRI_J[t]];
            tc = lens[TRI_K[t]];
            if (line_ok && !found && (int'(TRI_K[t]) < NUM_FIELDS)
                && ({1'b0, ta} < {1'b0, tb} + {1'b0, tc})
                && ({1'b0, tb} < {1'b0, ta} + {1'b0, tc})
                && ({1'b0, tc} < {1'b0, ta} + {1'b0, tb})) begin
                found = 1'b1;
                sa    = ta;
                sb    = tb;
                sc    = tc;
            end
        end
    end

    // result request control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept && is_end) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (in_accept && is_end) begin
            r_line_valid <= line_ok;
            r_found      <= found;
            r_side_a     <= sa;
            r_side_b     <= sb;
            r_side_c     <= sc;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_line_valid     = r_line_valid;
    assign o_triangle_found = r_found;
    assign o_side_a         = r_side_a;
    assign o_side_b         = r_side_b;
    assign o_side_c         = r_side_c;

`ifndef ASSERT_OFF
    // a found triple only on a valid line
    a_found_needs_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_found |-> r_line_valid)
        else $error("triangle reported on invalid line");

    // no triple means all sides zero
    a_sides_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_found |-> (r_side_a == '0) && (r_side_b == '0) && (r_side_c == '0))
        else $error("sides not cleared without triangle");

    // reported triple is a real triangle
    a_triangle_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_found |->
            ({1'b0, r_side_a} < {1'b0, r_side_b} + {1'b0, r_side_c}) &&
            ({1'b0, r_side_b} < {1'b0, r_side_a} + {1'b0, r_side_c}) &&
            ({1'b0, r_side_c} < {1'b0, r_side_a} + {1'b0, r_side_b}))
        else $error("reported triple breaks triangle inequality");

    // saturating counters stay bounded
    a_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count <= CNT_SAT) && (r_acc <= LEN_SAT))
        else $error("field count or accumulator out of bounds");

    // a line end produces a result and clears the line state
    a_end_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && is_end |=> r_out_valid && (r_count == '0) && (r_acc == '0) && !r_err)
        else $error("line end did not produce result");
`endif

endmodule
